FILE: hw/rtl/tplpt_pkg.sv
// Shared types, sizes and codes of the two-level page table manager.
package tplpt_pkg;

   localparam int DIR_ENTRIES     = 1024;
   localparam int DIR_AW          = 10;
   localparam int TABLE_SLOTS     = 16;
   localparam int SLOT_W          = 4;
   localparam int PAGE_IDX_W      = 10;
   localparam int TBL_AW          = SLOT_W + PAGE_IDX_W;
   localparam int PAGE_W          = 20;
   localparam int CUR_W           = PAGE_W + 1;
   localparam int FLAG_W          = 12;
   localparam int COUNT_W         = 11;
   localparam int MAX_RANGE_PAGES = 1024;
   localparam logic [CUR_W-1:0] TOTAL_PAGES = CUR_W'(1) << PAGE_W;

   localparam logic [1:0] CMD_CHECK  = 2'd0;
   localparam logic [1:0] CMD_MAP    = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;
   localparam logic [1:0] CMD_FREE   = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MAPPED  = 2'd1;
   localparam logic [1:0] ST_NO_SLOT = 2'd2;

   typedef struct packed {
      logic              present;
      logic [FLAG_W-1:0] flags;
      logic [SLOT_W-1:0] slot;
   } dir_entry_type;

   typedef struct packed {
      logic              present;
      logic [FLAG_W-1:0] flags;
      logic [PAGE_W-1:0] frame;
   } page_entry_type;

   typedef struct packed {
      logic [FLAG_W-1:0]  page_flags;
      logic [FLAG_W-1:0]  dir_flags;
      logic [PAGE_W-1:0]  phys_frame;
      logic [COUNT_W-1:0] page_count;
      logic [31:0]        virt_addr;
      logic [1:0]         command;
   } req_type;

   typedef struct packed {
      logic [PAGE_W-1:0] frame_out;
      logic              found;
      logic              range_unmapped;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic              alloc;
      logic [SLOT_W-1:0] slot;
      logic              free_all;
   } pool_ctl_type;

   typedef struct packed {
      logic              has_free;
      logic [SLOT_W-1:0] free_slot;
   } pool_status_type;

endpackage

FILE: hw/rtl/two_level_page_table_manager.sv
// Top level of the two-level page table manager: stream ports and result register.
// The block keeps a 1024-entry page directory and a pool of 16 page tables of
// 1024 entries each, and takes one command word at a time: a range check, a page
// map, a page lookup or a free of every table. A single sequencer walks both
// memories one registered read at a time and the block is not ready while it
// works. A map that needs a new table wipes the 1024 entries of the claimed
// slot. A range check covers at most 1024 pages: it examines each page inside
// a present table in turn and skips each absent 4 MiB region whole. Free-all
// clears the directory in one pass over its 1024 entries, and after reset the
// same pass runs before the first command word is accepted. A finished result
// waits in the output register, and the next command word is accepted while
// it waits.
module two_level_page_table_manager
   import tplpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[1:0], virt_addr[33:2], page_count[44:34], phys_frame[64:45],
   // dir_flags[76:65], page_flags[88:77], zero fill[95:89]
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], range_unmapped[2], found[3], frame_out[23:4]
   output logic [23:0] rsp_tdata
);

   logic            core_idle;
   logic            core_done;
   logic            core_take;
   rsp_type         core_result;
   req_type         req;
   pool_ctl_type    pool_ctl;
   pool_status_type pool_status;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   assign req        = req_tdata[$bits(req_type)-1:0];
   assign req_tready = core_idle;

   // The walker hands over its result only when the output register is free
   // or is being emptied in this cycle.
   assign core_take  = core_done && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (core_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   tplpt_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .start       (req_tvalid && core_idle),
      .req         (req),
      .idle        (core_idle),
      .done        (core_done),
      .result      (core_result),
      .take        (core_take),
      .pool_ctl    (pool_ctl),
      .pool_status (pool_status)
   );

   tplpt_slot_pool u_pool (
      .clock       (clock),
      .reset       (reset),
      .pool_ctl    (pool_ctl),
      .pool_status (pool_status)
   );

endmodule

FILE: hw/rtl/tplpt_slot_pool.sv
// Pool of page table slots: in-use bits and lowest free slot search.
module tplpt_slot_pool
   import tplpt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  pool_ctl_type    pool_ctl,
   output pool_status_type pool_status
);

   logic [TABLE_SLOTS-1:0] in_use_ff, in_use_in;

   always_comb begin
      pool_status = '0;
      for (int s = TABLE_SLOTS - 1; s >= 0; s--) begin
         if (!in_use_ff[s]) begin
            pool_status.has_free  = 1'b1;
            pool_status.free_slot = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      in_use_in = in_use_ff;
      if (pool_ctl.free_all) begin
         in_use_in = '0;
      end else if (pool_ctl.alloc) begin
         in_use_in[pool_ctl.slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else begin
         in_use_ff <= in_use_in;
      end
   end

endmodule

FILE: hw/rtl/tplpt_walker.sv
// Command sequencer with the directory and page table memories.
module tplpt_walker
   import tplpt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  req_type         req,
   output logic            idle,
   output logic            done,
   output rsp_type         result,
   input  logic            take,
   output pool_ctl_type    pool_ctl,
   input  pool_status_type pool_status
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DIR_RD = 3'd2;
   localparam logic [2:0] S_DIR_WT = 3'd3;
   localparam logic [2:0] S_TBL_WT = 3'd4;
   localparam logic [2:0] S_WIPE   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [1:0]            cmd_ff, cmd_in;
   logic [PAGE_W-1:0]     pg_ff, pg_in;
   logic [CUR_W-1:0]      cur_ff, cur_in;
   logic [CUR_W-1:0]      end_ff, end_in;
   logic [PAGE_W-1:0]     frame_ff, frame_in;
   logic [FLAG_W-1:0]     dflags_ff, dflags_in;
   logic [FLAG_W-1:0]     pflags_ff, pflags_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [PAGE_IDX_W-1:0] cnt_ff, cnt_in;
   logic                  free_ff, free_in;
   rsp_type               res_ff, res_in;

   dir_entry_type  dir_mem [DIR_ENTRIES];
   page_entry_type tbl_mem [TABLE_SLOTS * 1024];
   dir_entry_type  dir_q_ff;
   page_entry_type tbl_q_ff;

   logic           dir_we;
   logic [DIR_AW-1:0] dir_waddr, dir_raddr;
   dir_entry_type  dir_wdata;
   logic           tbl_we;
   logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
   page_entry_type tbl_wdata, new_entry;

   logic [COUNT_W-1:0] count_c;
   logic [CUR_W-1:0]   end_sum;

   assign idle   = (state_ff == S_IDLE);
   assign done   = (state_ff == S_DONE);
   assign result = res_ff;
   assign new_entry = '{present: 1'b1, flags: pflags_ff, frame: frame_ff};

   always_comb begin
      count_c = (req.page_count > COUNT_W'(MAX_RANGE_PAGES)) ?
                COUNT_W'(MAX_RANGE_PAGES) : req.page_count;
      end_sum = {1'b0, req.virt_addr[31:12]} + CUR_W'(count_c);
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      pg_in     = pg_ff;
      cur_in    = cur_ff;
      end_in    = end_ff;
      frame_in  = frame_ff;
      dflags_in = dflags_ff;
      pflags_in = pflags_ff;
      slot_in   = slot_ff;
      cnt_in    = cnt_ff;
      free_in   = free_ff;
      res_in    = res_ff;
      dir_we    = 1'b0;
      dir_waddr = cnt_ff;
      dir_wdata = '0;
      dir_raddr = cur_ff[PAGE_W-1:PAGE_IDX_W];
      tbl_we    = 1'b0;
      tbl_waddr = {slot_ff, cnt_ff};
      tbl_wdata = '0;
      tbl_raddr = {dir_q_ff.slot, cur_ff[PAGE_IDX_W-1:0]};
      pool_ctl  = '0;

      unique case (state_ff)
         S_CLEAR: begin
            dir_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (&cnt_ff) begin
               state_in = free_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in    = req.command;
               pg_in     = req.virt_addr[31:12];
               cur_in    = {1'b0, req.virt_addr[31:12]};
               frame_in  = req.phys_frame;
               dflags_in = req.dir_flags;
               pflags_in = req.page_flags;
               res_in    = '0;
               cnt_in    = '0;
               end_in    = {1'b0, req.virt_addr[31:12]} + CUR_W'(1);
               state_in  = S_DIR_RD;
               if (req.command == CMD_CHECK) begin
                  res_in.range_unmapped = 1'b1;
                  end_in = (end_sum > TOTAL_PAGES) ? TOTAL_PAGES : end_sum;
               end else if (req.command == CMD_FREE) begin
                  pool_ctl.free_all = 1'b1;
                  free_in  = 1'b1;
                  state_in = S_CLEAR;
               end
            end
         end
         S_DIR_RD: begin
            state_in = (cur_ff >= end_ff) ? S_DONE : S_DIR_WT;
         end
         S_DIR_WT: begin
            unique case (cmd_ff)
               CMD_CHECK: begin
                  if (dir_q_ff.present) begin
                     state_in = S_TBL_WT;
                  end else begin
                     cur_in   = {cur_ff[CUR_W-1:PAGE_IDX_W] + 1'b1, {PAGE_IDX_W{1'b0}}};
                     state_in = S_DIR_RD;
                  end
               end
               CMD_MAP: begin
                  if (dir_q_ff.present) begin
                     state_in = S_TBL_WT;
                  end else if (!pool_status.has_free) begin
                     res_in.status = ST_NO_SLOT;
                     state_in      = S_DONE;
                  end else begin
                     // A fresh table: claim the slot and wipe it, placing the new
                     // entry as the wipe passes its index.
                     pool_ctl.alloc = 1'b1;
                     pool_ctl.slot  = pool_status.free_slot;
                     slot_in        = pool_status.free_slot;
                     dir_we         = 1'b1;
                     dir_waddr      = pg_ff[PAGE_W-1:PAGE_IDX_W];
                     dir_wdata      = '{present: 1'b1, flags: dflags_ff,
                                        slot: pool_status.free_slot};
                     state_in       = S_WIPE;
                  end
               end
               CMD_LOOKUP: begin
                  state_in = dir_q_ff.present ? S_TBL_WT : S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_TBL_WT: begin
            state_in = S_DONE;
            unique case (cmd_ff)
               CMD_CHECK: begin
                  if (tbl_q_ff.present) begin
                     res_in.range_unmapped = 1'b0;
                  end else begin
                     cur_in   = cur_ff + 1'b1;
                     state_in = S_DIR_RD;
                  end
               end
               CMD_MAP: begin
                  if (tbl_q_ff.present) begin
                     res_in.status = ST_MAPPED;
                  end else begin
                     dir_we    = 1'b1;
                     dir_waddr = pg_ff[PAGE_W-1:PAGE_IDX_W];
                     dir_wdata = '{present: 1'b1, flags: dflags_ff, slot: dir_q_ff.slot};
                     tbl_we    = 1'b1;
                     tbl_waddr = {dir_q_ff.slot, pg_ff[PAGE_IDX_W-1:0]};
                     tbl_wdata = new_entry;
                  end
               end
               CMD_LOOKUP: begin
                  if (tbl_q_ff.present) begin
                     res_in.found     = 1'b1;
                     res_in.frame_out = tbl_q_ff.frame;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_WIPE: begin
            tbl_we    = 1'b1;
            tbl_wdata = (cnt_ff == pg_ff[PAGE_IDX_W-1:0]) ? new_entry : '0;
            cnt_in    = cnt_ff + 1'b1;
            if (&cnt_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            free_in = 1'b0;
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         free_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      pg_ff     <= pg_in;
      cur_ff    <= cur_in;
      end_ff    <= end_in;
      frame_ff  <= frame_in;
      dflags_ff <= dflags_in;
      pflags_ff <= pflags_in;
      slot_ff   <= slot_in;
      res_ff    <= res_in;
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      dir_q_ff <= dir_mem[dir_raddr];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      tbl_q_ff <= tbl_mem[tbl_raddr];
   end

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      done && !take |=> done && $stable(res_ff))
      else $error("finished result dropped before it was taken");

   a_status_map: assert property (@(posedge clock) disable iff (reset)
      done && res_ff.status != ST_OK |-> cmd_ff == CMD_MAP)
      else $error("error status on a command other than map");

   a_found_lookup: assert property (@(posedge clock) disable iff (reset)
      done && res_ff.found |-> cmd_ff == CMD_LOOKUP)
      else $error("lookup hit reported on another command");

   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      pool_ctl.alloc |-> pool_status.has_free && !dir_q_ff.present)
      else $error("slot claimed with the pool empty or a table present");

endmodule
